[hdl/tcw_pkg.sv]
// Shared types and constants for the text console writer.
// No dependencies; imported by tcw_ctrl, tcw_datapath and text_console_writer.
package tcw_pkg;

    // Input beat
    typedef struct packed {
        logic       mode;
        logic [7:0] char_code;
        logic [10:0] cell_index;
        logic       last_of_write;
    } t_in_item;

    // Output beat
    typedef struct packed {
        logic [10:0] cursor_cell;
        logic [7:0]  read_char;
        logic [7:0]  read_attr;
        logic        scrolled;
        logic        write_done;
    } t_out_item;

    localparam logic [7:0] CODE_NEWLINE   = 8'd10;
    localparam logic [7:0] CODE_TAB       = 8'd9;
    localparam logic [7:0] CODE_BACKSPACE = 8'd8;
    localparam logic [7:0] CODE_SPACE     = 8'd32;

    localparam logic       MODE_WRITE = 1'b0;
    localparam logic       MODE_READ  = 1'b1;

    localparam logic [7:0] TEXT_ATTR_RESET = 8'd7;

    // Decoded item operation
    typedef logic [2:0] t_op;
    localparam t_op OP_READ      = 3'd0;
    localparam t_op OP_CHAR      = 3'd1;
    localparam t_op OP_NEWLINE   = 3'd2;
    localparam t_op OP_TAB       = 3'd3;
    localparam t_op OP_BACKSPACE = 3'd4;

    // Controller -> datapath
    typedef struct packed {
        logic latch;       // take the input beat
        logic exec;        // perform the item's operation
        logic put_space;   // second space of a tab
        logic prime;       // start a scroll, first source read
        logic copy_step;   // copy one cell up by a row
        logic clear_step;  // zero one cell
        logic load;        // load the output register
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        t_op  op;
        logic at_last_cell;
        logic on_last_row;
        logic at_copy_end;
        logic at_clear_end;
        logic out_free;
    } t_dp_status;

endpackage

[hdl/tcw_ctrl.sv]
// Controller state machine for the text console writer.
// Depends on tcw_pkg; drives tcw_datapath through t_dp_cmd.
module tcw_ctrl #(
    parameter int ROWS        = 25,
    parameter int STATUS_ROWS = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tcw_pkg::t_dp_status i_status,
    output tcw_pkg::t_dp_cmd    o_cmd
);
    import tcw_pkg::*;

    localparam logic HAS_COPY = (STATUS_ROWS + 1 < ROWS);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_PUT2   = 3'd3;
    localparam logic [2:0] S_PRIME  = 3'd4;
    localparam logic [2:0] S_COPY   = 3'd5;
    localparam logic [2:0] S_CLRROW = 3'd6;
    localparam logic [2:0] S_LOAD   = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_tab2, n_tab2;
    logic       exec_wrap;

    // Would the item's own operation run off the end of the screen
    assign exec_wrap = ((i_status.op == OP_NEWLINE) && i_status.on_last_row) ||
                       (((i_status.op == OP_CHAR) || (i_status.op == OP_TAB)) &&
                        i_status.at_last_cell);

    always_comb begin
        n_state = r_state;
        n_tab2  = r_tab2;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.at_clear_end) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_status.out_free) begin
                    o_cmd.exec = 1'b1;
                    if (exec_wrap) begin
                        n_tab2  = (i_status.op == OP_TAB);
                        n_state = S_PRIME;
                    end else if (i_status.op == OP_TAB) begin
                        n_state = S_PUT2;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
            end
            S_PUT2: begin
                o_cmd.put_space = 1'b1;
                n_state = i_status.at_last_cell ? S_PRIME : S_LOAD;
            end
            S_PRIME: begin
                o_cmd.prime = 1'b1;
                n_state = HAS_COPY ? S_COPY : S_CLRROW;
            end
            S_COPY: begin
                o_cmd.copy_step = 1'b1;
                if (i_status.at_copy_end) n_state = S_CLRROW;
            end
            S_CLRROW: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.at_clear_end) begin
                    if (r_tab2) begin
                        n_tab2  = 1'b0;
                        n_state = S_PUT2;
                    end else begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_tab2  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tab2  <= n_tab2;
        end
    end

endmodule

[hdl/tcw_datapath.sv]
// Datapath for the text console writer: screen memory, cursor, sweep pointer,
// attribute register and output register. Depends on tcw_pkg.
module tcw_datapath #(
    parameter int COLUMNS     = 80,
    parameter int ROWS        = 25,
    parameter int STATUS_ROWS = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tcw_pkg::t_in_item   i_in_data,
    input  logic                i_cfg_valid,
    input  logic [7:0]          i_cfg_data,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output tcw_pkg::t_out_item  o_out_data,
    input  tcw_pkg::t_dp_cmd    i_cmd,
    output tcw_pkg::t_dp_status o_status
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int CW         = $clog2(CELL_COUNT);
    localparam int COLW       = $clog2(COLUMNS);

    localparam logic [CW-1:0]   LAST_CELL     = CW'(CELL_COUNT - 1);
    localparam logic [CW-1:0]   LAST_ROW_BASE = CW'((ROWS - 1) * COLUMNS);
    localparam logic [CW-1:0]   COPY_BASE     = CW'(STATUS_ROWS * COLUMNS);
    localparam logic [CW-1:0]   COPY_LAST     = CW'((ROWS - 1) * COLUMNS - 1);
    localparam logic [COLW-1:0] COL_LAST      = COLW'(COLUMNS - 1);
    localparam logic            HAS_COPY      = (STATUS_ROWS + 1 < ROWS);

    logic [15:0] mem [CELL_COUNT];

    logic [CW-1:0]   r_cursor, n_cursor;
    logic [COLW-1:0] r_col, n_col;
    logic [CW-1:0]   r_ptr, n_ptr;
    logic [7:0]      r_attr;
    logic            r_scrolled, n_scrolled;
    t_op             r_op;
    logic [7:0]      r_ch;
    logic [CW-1:0]   r_rd_addr;
    logic            r_in_range;
    logic            r_last;
    logic [15:0]     r_rdata;
    logic            r_out_valid;
    t_out_item       r_out;

    t_op             in_op;
    logic            in_range;
    logic [CW-1:0]   in_addr;
    logic [CW:0]     src_wide;
    logic [CW-1:0]   rd_addr;
    logic            do_put, do_nl, do_bs, wrap;
    logic            at_last_cell, on_last_row;
    logic [CW-1:0]   bs_cursor;
    logic            w_en;
    logic [CW-1:0]   w_addr;
    logic [15:0]     w_data;
    logic            out_free;

    // Input decode
    always_comb begin
        if (i_in_data.mode == MODE_READ)                in_op = OP_READ;
        else if (i_in_data.char_code == CODE_NEWLINE)   in_op = OP_NEWLINE;
        else if (i_in_data.char_code == CODE_TAB)       in_op = OP_TAB;
        else if (i_in_data.char_code == CODE_BACKSPACE) in_op = OP_BACKSPACE;
        else                                            in_op = OP_CHAR;
    end

    assign in_range = (32'(i_in_data.cell_index) < 32'(CELL_COUNT));
    assign in_addr  = in_range ? CW'(i_in_data.cell_index) : '0;

    assign at_last_cell = (r_cursor == LAST_CELL);
    assign on_last_row  = (r_cursor >= LAST_ROW_BASE);
    assign bs_cursor    = (r_cursor == '0) ? '0 : r_cursor - CW'(1);

    assign do_put = (i_cmd.exec && ((r_op == OP_CHAR) || (r_op == OP_TAB))) || i_cmd.put_space;
    assign do_nl  = i_cmd.exec && (r_op == OP_NEWLINE);
    assign do_bs  = i_cmd.exec && (r_op == OP_BACKSPACE);
    assign wrap   = (do_put && at_last_cell) || (do_nl && on_last_row);

    // Sweep pointer
    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.clear_step || i_cmd.copy_step) n_ptr = r_ptr + CW'(1);
        else if (i_cmd.prime)                    n_ptr = HAS_COPY ? COPY_BASE : LAST_ROW_BASE;
    end

    // Read address: one row below the next copy target while scrolling
    assign src_wide = {1'b0, n_ptr} + (CW+1)'(COLUMNS);
    always_comb begin
        if (i_cmd.prime || i_cmd.copy_step)
            rd_addr = (src_wide > {1'b0, LAST_CELL}) ? '0 : src_wide[CW-1:0];
        else if (i_cmd.latch)
            rd_addr = in_addr;
        else
            rd_addr = r_rd_addr;
    end

    // Write port
    always_comb begin
        w_en   = 1'b0;
        w_addr = r_cursor;
        w_data = {r_attr, CODE_SPACE};
        if (i_cmd.clear_step) begin
            w_en   = 1'b1;
            w_addr = r_ptr;
            w_data = '0;
        end else if (i_cmd.copy_step) begin
            w_en   = 1'b1;
            w_addr = r_ptr;
            w_data = r_rdata;
        end else if (do_put) begin
            w_en = 1'b1;
            if (i_cmd.exec && (r_op == OP_CHAR)) w_data = {r_attr, r_ch};
        end else if (do_bs) begin
            w_en   = 1'b1;
            w_addr = bs_cursor;
        end
    end

    // Cursor and column
    always_comb begin
        n_cursor = r_cursor;
        n_col    = r_col;
        if (wrap) begin
            n_cursor = LAST_ROW_BASE;
            n_col    = '0;
        end else if (do_put) begin
            n_cursor = r_cursor + CW'(1);
            n_col    = (r_col == COL_LAST) ? '0 : r_col + COLW'(1);
        end else if (do_nl) begin
            n_cursor = r_cursor - CW'(r_col) + CW'(COLUMNS);
            n_col    = '0;
        end else if (do_bs && (r_cursor != '0)) begin
            n_cursor = bs_cursor;
            n_col    = (r_col == '0) ? COL_LAST : r_col - COLW'(1);
        end
    end

    assign n_scrolled = i_cmd.latch ? 1'b0 : (r_scrolled | wrap);
    assign out_free   = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (w_en) mem[w_addr] <= w_data;
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor    <= '0;
            r_col       <= '0;
            r_ptr       <= '0;
            r_attr      <= TEXT_ATTR_RESET;
            r_scrolled  <= 1'b0;
            r_op        <= OP_READ;
            r_out_valid <= 1'b0;
        end else begin
            r_cursor   <= n_cursor;
            r_col      <= n_col;
            r_ptr      <= n_ptr;
            r_scrolled <= n_scrolled;
            if (i_cfg_valid) r_attr <= i_cfg_data;
            if (i_cmd.latch) r_op <= in_op;
            if (i_cmd.load)    r_out_valid <= 1'b1;
            else if (out_free) r_out_valid <= 1'b0;
        end
    end

    // Item payload and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_ch       <= i_in_data.char_code;
            r_rd_addr  <= in_addr;
            r_in_range <= in_range;
            r_last     <= i_in_data.last_of_write;
        end
        if (i_cmd.load) begin
            r_out.cursor_cell <= 11'(n_cursor);
            r_out.read_char   <= ((r_op == OP_READ) && r_in_range) ? r_rdata[7:0] : 8'd0;
            r_out.read_attr   <= ((r_op == OP_READ) && r_in_range) ? r_rdata[15:8] : 8'd0;
            r_out.scrolled    <= r_scrolled;
            r_out.write_done  <= (r_op != OP_READ) ? r_last : 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign o_status.op           = r_op;
    assign o_status.at_last_cell = at_last_cell;
    assign o_status.on_last_row  = on_last_row;
    assign o_status.at_copy_end  = (r_ptr == COPY_LAST);
    assign o_status.at_clear_end = (r_ptr == LAST_CELL);
    assign o_status.out_free     = out_free;

endmodule

[hdl/text_console_writer.sv]
// Character-cell text console, top level. Depends on tcw_pkg, tcw_ctrl and
// tcw_datapath.
//
// Keeps a ROWS x COLUMNS screen of 16-bit cells (character low byte,
// attribute high byte) and a cursor. Write-mode beats store one character
// with the configured attribute (newline, tab as two spaces, backspace
// handled), read-mode beats return one cell; every input beat yields exactly
// one output beat. An ordinary character, newline, backspace or read is
// accepted, then performs one memory write or registered read; a tab is
// accepted, then writes two spaces. The screen memory, one write and one
// registered read per cycle, sets the scroll cost: a scroll copies the rows
// below the STATUS_ROWS status rows one cell per cycle and then zeroes the
// last row one cell per cycle; input is stalled meanwhile. After reset the
// block zeroes the whole screen before taking its first beat; attribute
// writes are taken at any time. The next beat is accepted while a finished
// result still waits on o_out_valid.
module text_console_writer #(
    parameter int COLUMNS     = 80,
    parameter int ROWS        = 25,
    parameter int STATUS_ROWS = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input beats
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tcw_pkg::t_in_item  i_in_data,
    // result beats
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tcw_pkg::t_out_item o_out_data,
    // attribute register write
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_data
);
    import tcw_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // Attribute register is a plain flop; always writable.
    assign o_cfg_ready = 1'b1;

    tcw_ctrl #(
        .ROWS        (ROWS),
        .STATUS_ROWS (STATUS_ROWS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tcw_datapath #(
        .COLUMNS     (COLUMNS),
        .ROWS        (ROWS),
        .STATUS_ROWS (STATUS_ROWS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid & o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule

[sim/tb_text_console_writer.sv]
`timescale 1ns / 1ps
// Self-checking testbench for text_console_writer: queue-fed beat driver, result monitor,
// built-in screen/cursor predictor. Depends on tcw_pkg and the text_console_writer RTL.
module tb_text_console_writer;
    import tcw_pkg::*;

    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS    = 25;
    localparam int STATUS_ROWS    = 2;
    localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int LAST_ROW_START = (SCREEN_ROWS - 1) * SCREEN_COLUMNS;
    // Longest legal quiet stretch is the post-reset clear or one scroll plus a
    // receiver stall tail; this leaves a wide margin.
    localparam int QUIET_LIMIT    = 20000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    t_in_item   in_beat = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_item  out_beat;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = '0;

    // Beats waiting to be driven, and results owed by the block
    t_in_item  pending_beats[$];
    t_out_item expected_results[$];

    // Predictor state: screen cells {attr, char}, cursor, attribute register
    logic [15:0] screen_model [0:CELL_COUNT-1];
    int          cursor_model;
    logic [7:0]  attr_model;

    int          send_idle_pct = 11;
    int          out_stall_pct = 54;
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    t_out_item   want_result;

    text_console_writer #(
        .COLUMNS     (SCREEN_COLUMNS),
        .ROWS        (SCREEN_ROWS),
        .STATUS_ROWS (STATUS_ROWS)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    // Rows below the status rows move up one, last row blanks, cursor to its start.
    function automatic void scroll_screen();
        int c;
        for (c = STATUS_ROWS * SCREEN_COLUMNS; c < LAST_ROW_START; c++) begin
            screen_model[c] = screen_model[c + SCREEN_COLUMNS];
        end
        for (c = LAST_ROW_START; c < CELL_COUNT; c++) begin
            screen_model[c] = '0;
        end
        cursor_model = LAST_ROW_START;
    endfunction

    // Store one character at the cursor and advance; 1 when that ran off the end.
    function automatic bit put_char(logic [7:0] ch);
        screen_model[cursor_model] = {attr_model, ch};
        cursor_model++;
        if (cursor_model >= CELL_COUNT) begin
            scroll_screen();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_out_item console_predict(t_in_item beat);
        t_out_item r;
        r = '0;
        if (beat.mode == MODE_READ) begin
            // out-of-range cells read back as zero
            if (beat.cell_index < CELL_COUNT) begin
                r.read_char = screen_model[beat.cell_index][7:0];
                r.read_attr = screen_model[beat.cell_index][15:8];
            end
        end else begin
            r.write_done = beat.last_of_write;
            case (beat.char_code)
                CODE_NEWLINE: begin
                    cursor_model += SCREEN_COLUMNS - (cursor_model % SCREEN_COLUMNS);
                    if (cursor_model >= CELL_COUNT) begin
                        scroll_screen();
                        r.scrolled = 1'b1;
                    end
                end
                CODE_TAB: begin
                    // each space may scroll on its own
                    if (put_char(CODE_SPACE)) r.scrolled = 1'b1;
                    if (put_char(CODE_SPACE)) r.scrolled = 1'b1;
                end
                CODE_BACKSPACE: begin
                    // floored at cell 0; the blanking write never scrolls
                    if (cursor_model > 0) cursor_model--;
                    void'(put_char(CODE_SPACE));
                    cursor_model--;
                end
                default: begin
                    if (put_char(beat.char_code)) r.scrolled = 1'b1;
                end
            endcase
        end
        r.cursor_cell = 11'(cursor_model);
        return r;
    endfunction

    // ---------------------------------------------------------------- driver

    // Predict at acceptance; only advance the payload when the current beat is gone.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                expected_results.push_back(console_predict(in_beat));
            end
            if (!in_valid || !in_stall) begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_beat  <= pending_beats.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result beat, cursor_cell", out_beat.cursor_cell, -1);
            end else begin
                want_result = expected_results.pop_front();
                if (out_beat.cursor_cell !== want_result.cursor_cell)
                    report_mismatch("cursor_cell", out_beat.cursor_cell, want_result.cursor_cell);
                if (out_beat.read_char !== want_result.read_char)
                    report_mismatch("read_char", out_beat.read_char, want_result.read_char);
                if (out_beat.read_attr !== want_result.read_attr)
                    report_mismatch("read_attr", out_beat.read_attr, want_result.read_attr);
                if (out_beat.scrolled !== want_result.scrolled)
                    report_mismatch("scrolled", out_beat.scrolled, want_result.scrolled);
                if (out_beat.write_done !== want_result.write_done)
                    report_mismatch("write_done", out_beat.write_done, want_result.write_done);
            end
        end
        out_stall <= rst_n && ($urandom_range(99) < out_stall_pct);
    end

    // Watchdog: no beat on any channel for too long means the block hung.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_text_console_writer: errors");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic queue_beat(input logic mode, input logic [7:0] ch,
                              input logic [10:0] idx, input logic last);
        t_in_item b;
        b.mode          = mode;
        b.char_code     = ch;
        b.cell_index    = idx;
        b.last_of_write = last;
        pending_beats.push_back(b);
    endtask

    // Mostly plain bytes, a fair share of control codes.
    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 6)  return CODE_NEWLINE;
        if (r < 12) return CODE_TAB;
        if (r < 18) return CODE_BACKSPACE;
        return 8'($urandom_range(255));
    endfunction

    // Reads favor the last two rows, where fresh text lands; some go past the screen.
    function automatic logic [10:0] pick_cell();
        int r;
        r = $urandom_range(99);
        if (r < 50) return 11'($urandom_range(CELL_COUNT - 1, LAST_ROW_START - SCREEN_COLUMNS));
        if (r < 85) return 11'($urandom_range(CELL_COUNT - 1));
        return 11'($urandom_range(2047));
    endfunction

    // Fill-row burst: newline to the last row, fill_len chars, then a tab that
    // straddles the screen end (78 -> second space scrolls, 79 -> first does).
    // After that, write requests of random length mixed with cell reads.
    task automatic queue_random_traffic(input int count, input int fill_len);
        int n;
        int len;
        queue_beat(MODE_WRITE, CODE_NEWLINE, 11'($urandom_range(2047)), 1'b0);
        for (int j = 0; j < fill_len; j++)
            queue_beat(MODE_WRITE, 8'($urandom_range(126, 33)), 11'($urandom_range(2047)), 1'b0);
        queue_beat(MODE_WRITE, CODE_TAB, 11'($urandom_range(2047)), 1'b1);
        n = 0;
        while (n < count) begin
            if ($urandom_range(3) == 0) begin
                queue_beat(MODE_READ, 8'($urandom_range(255)), pick_cell(),
                           1'($urandom_range(1)));
                n++;
            end else begin
                len = $urandom_range(12, 1);
                for (int j = 0; j < len; j++)
                    queue_beat(MODE_WRITE, pick_char(), 11'($urandom_range(2047)),
                               (j == len - 1));
                n += len;
            end
        end
    endtask

    // Block is idle once nothing is queued, on the wire, or owed.
    task automatic wait_idle();
        while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_attribute(input logic [7:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid  <= 1'b0;
        attr_model  = value;
    endtask

    // One random phase: sender pauses until drained, new attribute, new idling mix.
    task automatic run_phase(input logic [7:0] attr, input int idle_pct, input int stall_pct,
                             input int bottom_walk, input int fill_len);
        wait_idle();
        write_attribute(attr);
        send_idle_pct <= idle_pct;
        out_stall_pct <= stall_pct;
        // walking the cursor down row by row ends with a newline on the last row
        for (int j = 0; j < bottom_walk; j++)
            queue_beat(MODE_WRITE, CODE_NEWLINE, 11'($urandom_range(2047)), 1'b1);
        queue_random_traffic(55, fill_len);
    endtask

    initial begin
        for (int c = 0; c < CELL_COUNT; c++) screen_model[c] = '0;
        cursor_model = 0;
        attr_model   = TEXT_ATTR_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed beats, reset attribute. Reads of the cleared screen and past its end.
        queue_beat(MODE_READ,  8'h00,          11'd0,    1'b0);
        queue_beat(MODE_READ,  8'hFF,          11'd2047, 1'b1);
        queue_beat(MODE_READ,  8'h00,          11'd1999, 1'b0);
        queue_beat(MODE_READ,  8'h00,          11'd2000, 1'b0);
        // backspace at cell zero: cursor stays, cell 0 blanked
        queue_beat(MODE_WRITE, CODE_BACKSPACE, 11'd0,    1'b0);
        queue_beat(MODE_READ,  8'h00,          11'd0,    1'b0);
        // byte extremes, tab, backspace, newline
        queue_beat(MODE_WRITE, 8'h00,          11'd2047, 1'b0);
        queue_beat(MODE_WRITE, 8'hFF,          11'd0,    1'b1);
        queue_beat(MODE_WRITE, CODE_TAB,       11'd0,    1'b1);
        queue_beat(MODE_WRITE, CODE_BACKSPACE, 11'd0,    1'b0);
        queue_beat(MODE_WRITE, CODE_NEWLINE,   11'd0,    1'b1);
        queue_beat(MODE_READ,  8'h00,          11'd1,    1'b0);
        queue_beat(MODE_READ,  8'h00,          11'd3,    1'b1);

        run_phase(8'h00, 11, 54, SCREEN_ROWS, SCREEN_COLUMNS - 2);
        run_phase(8'hFF, 54, 11, 0, SCREEN_COLUMNS - 1);
        run_phase(8'($urandom_range(254, 1)), 0, 0, 0, SCREEN_COLUMNS - 1 - $urandom_range(1));

        wait_idle();
        repeat (16) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("tb_text_console_writer: clean");
        end else begin
            $display("tb_text_console_writer: errors");
        end
        $finish;
    end

endmodule

[text_console_writer.f]
hdl/tcw_pkg.sv
hdl/tcw_ctrl.sv
hdl/tcw_datapath.sv
hdl/text_console_writer.sv
sim/tb_text_console_writer.sv
